// File: src/dva_pkg.sv
// Shared constants, types and the velocity-to-gain table of the drum voice allocator.
// Used by drum_voice_allocator; depends on nothing else.
package dva_pkg;

  localparam int unsigned VOICES     = 32;
  localparam int unsigned POS_BITS   = 24;
  localparam int unsigned REF_BITS   = 16;
  localparam int unsigned SLOT_W     = $clog2(VOICES);
  localparam int unsigned COUNT_W    = $clog2(VOICES + 1);
  localparam int unsigned SLOT_OUT_W = 6;
  localparam int unsigned FREED_W    = 7;
  localparam int unsigned CHAN_W     = 4;
  localparam int unsigned GROUP_W    = 4;
  localparam int unsigned VEL_W      = 7;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned GAIN_DEN   = 635;

  typedef enum logic [1:0] {
    FUNC_CHOKE = 2'd0,
    FUNC_START = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STAT_START_FREE  = 3'd0,
    STAT_START_STEAL = 3'd1,
    STAT_START_IGN   = 3'd2,
    STAT_FETCH       = 3'd3,
    STAT_CHOKE_DONE  = 3'd4,
    STAT_TICK_IDLE   = 3'd5
  } status_t;

  // One voice table entry as it sits in the voice RAM.
  typedef struct packed {
    logic [REF_BITS-1:0] sref;
    logic [POS_BITS-1:0] pos;
    logic [POS_BITS-1:0] len;
    logic [CHAN_W-1:0]   chan;
    logic [GROUP_W-1:0]  choke;
    logic [GAIN_W-1:0]   gain;
  } voice_rec_t;

  typedef logic [GAIN_W-1:0] gain_lut_t [2**VEL_W];

  // gain = floor(32768 * (254 + 3*vel) / 635), worked out at elaboration.
  function automatic gain_lut_t build_gain_lut();
    gain_lut_t lut;
    for (int v = 0; v < 2**VEL_W; v++) begin
      lut[v] = GAIN_W'((32'd32768 * (32'd254 + 32'd3 * 32'(v))) / GAIN_DEN);
    end
    return lut;
  endfunction

  localparam gain_lut_t GAIN_LUT = build_gain_lut();

endpackage

// File: src/dva_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used by drum_voice_allocator for the voice table.
module dva_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/drum_voice_allocator.sv
// Top level of the drum voice allocator: command port, slot sequencer and result register.
// Depends on dva_pkg and on dva_ram, which holds the voice table.

// A command word is taken on a clock edge where start is high and busy is low.
// A choke with a nonzero group, a start with a nonzero length and a tick with at
// least one playing voice each walk the whole voice table through the single read
// port of the voice RAM, one slot per cycle; busy stays high through the walk and
// the ST_TAIL and ST_FIN states after it, and no new word is taken until it falls.
// A choke with group zero, a start with zero length, a tick with no playing voice
// and the unused function code finish at once: busy never rises and another word
// may follow in the next cycle. Every result word appears on the out_ ports for
// exactly one cycle with out_valid high, after its command was taken; the receiver
// must take it then, as nothing here holds a result back. A tick sends one fetch
// word per playing voice in slot order, each as that slot is reached in the walk,
// with out_last set on the highest playing slot; start and choke send a single
// word once the walk is over.
module drum_voice_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_func,
  input  logic [dva_pkg::REF_BITS-1:0]     in_sample_ref,
  input  logic [dva_pkg::POS_BITS-1:0]     in_sample_length,
  input  logic [dva_pkg::CHAN_W-1:0]       in_out_channel,
  input  logic [dva_pkg::GROUP_W-1:0]      in_choke_group,
  input  logic [dva_pkg::VEL_W-1:0]        in_velocity,
  output logic                             out_valid,
  output logic [2:0]                       out_status,
  output logic [dva_pkg::SLOT_OUT_W-1:0]   out_slot,
  output logic [dva_pkg::REF_BITS-1:0]     out_ref_out,
  output logic [dva_pkg::POS_BITS-1:0]     out_position,
  output logic [dva_pkg::CHAN_W-1:0]       out_channel_out,
  output logic [dva_pkg::GAIN_W-1:0]       out_gain,
  output logic [dva_pkg::FREED_W-1:0]      out_freed_count,
  output logic                             out_last
);

  import dva_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_FIN
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(VOICES - 1);

  // Sequencer and control state.
  state_t              state_r, state_nxt;
  func_t               op_r, op_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic                proc_valid_r, proc_valid_nxt;
  logic [SLOT_W-1:0]   proc_idx_r, proc_idx_nxt;
  logic [VOICES-1:0]   active_r, active_nxt;

  // Per-command working registers.
  logic [REF_BITS-1:0] ref_r, ref_nxt;
  logic [POS_BITS-1:0] len_r, len_nxt;
  logic [CHAN_W-1:0]   chan_r, chan_nxt;
  logic [GROUP_W-1:0]  grp_r, grp_nxt;
  logic [VEL_W-1:0]    vel_r, vel_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic                found_r, found_nxt;
  logic [SLOT_W-1:0]   free_slot_r, free_slot_nxt;
  logic [POS_BITS-1:0] best_r, best_nxt;
  logic [SLOT_W-1:0]   best_slot_r, best_slot_nxt;

  // Result register.
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  logic [REF_BITS-1:0]   out_ref_r, out_ref_nxt;
  logic [POS_BITS-1:0]   out_pos_r, out_pos_nxt;
  logic [CHAN_W-1:0]     out_chan_r, out_chan_nxt;
  logic [GAIN_W-1:0]     out_gain_r, out_gain_nxt;
  logic [FREED_W-1:0]    out_freed_r, out_freed_nxt;
  logic                  out_last_r, out_last_nxt;

  // Voice RAM port signals.
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  voice_rec_t          ram_wdata;
  logic [SLOT_W-1:0]   ram_raddr;
  voice_rec_t          rd;

  // Per-slot helpers for the entry being processed.
  logic [POS_BITS-1:0] next_pos;
  logic [VOICES-1:0]   above_mask;
  logic [SLOT_W-1:0]   slot_sel;

  dva_ram #(
    .WIDTH ($bits(voice_rec_t)),
    .DEPTH (VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  assign next_pos   = rd.pos + POS_BITS'(1);
  assign above_mask = ({VOICES{1'b1}} << proc_idx_r) << 1;
  assign slot_sel   = found_r ? free_slot_r : best_slot_r;
  assign ram_raddr  = idx_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    proc_valid_nxt = 1'b0;
    proc_idx_nxt   = proc_idx_r;
    active_nxt     = active_r;
    ref_nxt        = ref_r;
    len_nxt        = len_r;
    chan_nxt       = chan_r;
    grp_nxt        = grp_r;
    vel_nxt        = vel_r;
    cnt_nxt        = cnt_r;
    found_nxt      = found_r;
    free_slot_nxt  = free_slot_r;
    best_nxt       = best_r;
    best_slot_nxt  = best_slot_r;

    out_valid_nxt  = 1'b0;
    out_status_nxt = STAT_TICK_IDLE;
    out_slot_nxt   = '0;
    out_ref_nxt    = '0;
    out_pos_nxt    = '0;
    out_chan_nxt   = '0;
    out_gain_nxt   = '0;
    out_freed_nxt  = '0;
    out_last_nxt   = 1'b0;

    ram_we    = 1'b0;
    ram_waddr = proc_idx_r;
    ram_wdata = rd;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt  = func_t'(in_func);
          idx_nxt = '0;
          unique case (func_t'(in_func))
            FUNC_CHOKE: begin
              if (in_choke_group == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_CHOKE_DONE;
                out_last_nxt   = 1'b1;
              end else begin
                grp_nxt   = in_choke_group;
                cnt_nxt   = '0;
                state_nxt = ST_SCAN;
              end
            end
            FUNC_START: begin
              if (in_sample_length == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_START_IGN;
                out_last_nxt   = 1'b1;
              end else begin
                ref_nxt       = in_sample_ref;
                len_nxt       = in_sample_length;
                chan_nxt      = in_out_channel;
                grp_nxt       = in_choke_group;
                vel_nxt       = in_velocity;
                found_nxt     = 1'b0;
                free_slot_nxt = '0;
                best_nxt      = '0;
                best_slot_nxt = '0;
                state_nxt     = ST_SCAN;
              end
            end
            FUNC_TICK: begin
              if (active_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_TICK_IDLE;
                out_last_nxt   = 1'b1;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            FUNC_NONE: begin
              // Unused code: nothing happens and nothing is reported.
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue one RAM read per cycle; the data comes back in the next cycle.
        proc_valid_nxt = 1'b1;
        proc_idx_nxt   = idx_r;
        if (idx_r == LAST_SLOT) begin
          state_nxt = ST_TAIL;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end

      ST_TAIL: begin
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        state_nxt = ST_IDLE;
        unique case (op_r)
          FUNC_START: begin
            ram_we         = 1'b1;
            ram_waddr      = slot_sel;
            ram_wdata.sref = ref_r;
            ram_wdata.pos  = '0;
            ram_wdata.len  = len_r;
            ram_wdata.chan = chan_r;
            ram_wdata.choke = grp_r;
            ram_wdata.gain = GAIN_LUT[vel_r];
            active_nxt[slot_sel] = 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = found_r ? STAT_START_FREE : STAT_START_STEAL;
            out_slot_nxt   = SLOT_OUT_W'(slot_sel);
            out_last_nxt   = 1'b1;
          end
          FUNC_CHOKE: begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_CHOKE_DONE;
            out_freed_nxt  = FREED_W'(cnt_r);
            out_last_nxt   = 1'b1;
          end
          FUNC_TICK, FUNC_NONE: begin
            // Tick results went out during the walk.
          end
        endcase
      end
    endcase

    // Handle the table entry whose read data is now on the RAM output.
    if (proc_valid_r) begin
      unique case (op_r)
        FUNC_CHOKE: begin
          if (active_r[proc_idx_r] && rd.choke == grp_r) begin
            active_nxt[proc_idx_r] = 1'b0;
            cnt_nxt = cnt_r + COUNT_W'(1);
          end
        end
        FUNC_START: begin
          // Lowest free slot wins; otherwise the first slot at the greatest position.
          if (!active_r[proc_idx_r]) begin
            if (!found_r) begin
              found_nxt     = 1'b1;
              free_slot_nxt = proc_idx_r;
            end
          end else if (rd.pos > best_r) begin
            best_nxt      = rd.pos;
            best_slot_nxt = proc_idx_r;
          end
        end
        FUNC_TICK: begin
          if (active_r[proc_idx_r]) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_FETCH;
            out_slot_nxt   = SLOT_OUT_W'(proc_idx_r);
            out_ref_nxt    = rd.sref;
            out_pos_nxt    = rd.pos;
            out_chan_nxt   = rd.chan;
            out_gain_nxt   = rd.gain;
            out_last_nxt   = ((active_r & above_mask) == '0);
            ram_we         = 1'b1;
            ram_waddr      = proc_idx_r;
            ram_wdata.pos  = next_pos;
            // A voice ends at its length, or when its position wraps to zero.
            if (next_pos >= rd.len || next_pos == '0) begin
              active_nxt[proc_idx_r] = 1'b0;
            end
          end
        end
        FUNC_NONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      op_r         <= FUNC_NONE;
      idx_r        <= '0;
      proc_valid_r <= 1'b0;
      active_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      idx_r        <= idx_nxt;
      proc_valid_r <= proc_valid_nxt;
      active_r     <= active_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    proc_idx_r   <= proc_idx_nxt;
    ref_r        <= ref_nxt;
    len_r        <= len_nxt;
    chan_r       <= chan_nxt;
    grp_r        <= grp_nxt;
    vel_r        <= vel_nxt;
    cnt_r        <= cnt_nxt;
    found_r      <= found_nxt;
    free_slot_r  <= free_slot_nxt;
    best_r       <= best_nxt;
    best_slot_r  <= best_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_ref_r    <= out_ref_nxt;
    out_pos_r    <= out_pos_nxt;
    out_chan_r   <= out_chan_nxt;
    out_gain_r   <= out_gain_nxt;
    out_freed_r  <= out_freed_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_ref_out     = out_ref_r;
  assign out_position    = out_pos_r;
  assign out_channel_out = out_chan_r;
  assign out_gain        = out_gain_r;
  assign out_freed_count = out_freed_r;
  assign out_last        = out_last_r;

endmodule
